/* design/mrt_hdr_pkg.sv */
// Shared types, codes, tables and helpers of the MRT record header parser.
package mrt_hdr_pkg;

    // Results one record byte can produce at most
    localparam int MAX_RESULTS = 3;
    localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);
    localparam int RESULT_QUEUE_DEPTH = 8;

    // Byte position counter width; saturates well past the last decoded field
    localparam int POS_W = 7;

    // Header layout, byte positions within the record
    localparam logic [POS_W-1:0] POS_SEC_END = POS_W'(3);
    localparam logic [POS_W-1:0] POS_TYPE_END = POS_W'(5);
    localparam logic [POS_W-1:0] POS_SUBTYPE_END = POS_W'(7);
    localparam logic [POS_W-1:0] POS_LEN_END = POS_W'(11);
    localparam logic [POS_W-1:0] HDR_LEN = POS_W'(12);
    localparam logic [POS_W-1:0] EXT_HDR_LEN = POS_W'(16);
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // BGP4MP body layout sizes in bytes
    localparam logic [POS_W-1:0] AS2_LEN = POS_W'(2);
    localparam logic [POS_W-1:0] AS4_LEN = POS_W'(4);
    localparam logic [POS_W-1:0] IFACE_AFI_LEN = POS_W'(4);
    localparam logic [POS_W-1:0] V4_LEN = POS_W'(4);
    localparam logic [POS_W-1:0] V6_LEN = POS_W'(16);
    localparam logic [POS_W-1:0] ADDR_WORD_LEN = POS_W'(8);
    localparam logic [POS_W-1:0] STATE_PAIR_LEN = POS_W'(4);

    localparam logic [31:0] EXT_STAMP_LEN = 32'd4;
    localparam int NS_PER_US = 1000;

    // Record types and address families
    localparam logic [15:0] TYPE_TABLE_DUMP_V2 = 16'd13;
    localparam logic [15:0] TYPE_BGP4MP = 16'd16;
    localparam logic [15:0] TYPE_BGP4MP_ET = 16'd17;
    localparam logic [15:0] ADDR_FAMILY_V4 = 16'd1;
    localparam logic [15:0] ADDR_FAMILY_V6 = 16'd2;

    // Class flag bits
    localparam int CF_VALID = 0;
    localparam int CF_AS32 = 1;
    localparam int CF_EXT = 4;
    localparam int CF_BGP = 5;
    localparam int CF_STATE = 6;
    localparam int CF_WRAPS = 7;

    localparam logic [8:0] BGP_CLASS [12] = '{
        9'h061, 9'h0A1, 9'h000, 9'h000, 9'h0A3, 9'h063,
        9'h0A1, 9'h0A3, 9'h1A1, 9'h1A3, 9'h1A1, 9'h1A3
    };

    localparam logic [8:0] DUMP2_CLASS [13] = '{
        9'h000, 9'h005, 9'h009, 9'h009, 9'h009, 9'h009, 9'h009,
        9'h000, 9'h109, 9'h109, 9'h109, 9'h109, 9'h109
    };

    typedef enum logic [4:0] {
        FC_SEC           = 5'd0,
        FC_NSEC          = 5'd1,
        FC_TYPE          = 5'd2,
        FC_SUBTYPE       = 5'd3,
        FC_LENGTH        = 5'd4,
        FC_CLASS         = 5'd5,
        FC_PEER_AS       = 5'd6,
        FC_LOCAL_AS      = 5'd7,
        FC_IFACE         = 5'd8,
        FC_AFI           = 5'd9,
        FC_PEER_ADDR_HI  = 5'd10,
        FC_PEER_ADDR_LO  = 5'd11,
        FC_LOCAL_ADDR_HI = 5'd12,
        FC_LOCAL_ADDR_LO = 5'd13,
        FC_OLD_STATE     = 5'd14,
        FC_NEW_STATE     = 5'd15,
        FC_PAYLOAD_LEN   = 5'd16,
        FC_STATUS        = 5'd17
    } field_code_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_HEADER = 2'd1,
        ST_TRUNCATED  = 2'd2,
        ST_BAD_AFI    = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       record_end;
    } rec_beat_t;

    typedef struct packed {
        logic [4:0]  field_code;
        logic [63:0] value;
        logic        is_last;
    } result_t;

    // Results produced by one record byte, filled from item[0] upward
    typedef struct packed {
        logic [RES_CNT_W-1:0]          count;
        result_t [MAX_RESULTS-1:0]     item;
    } result_bundle_t;

    // Map record type and subtype to class flags
    function automatic logic [8:0] classify(input logic [15:0] rtype, input logic [15:0] rsub);
        logic [8:0] cls;
        cls = '0;
        if (rtype == TYPE_BGP4MP && rsub < 16'd12)
        begin
            cls = BGP_CLASS[rsub[3:0]];
        end
        else if (rtype == TYPE_BGP4MP_ET && rsub < 16'd12 && BGP_CLASS[rsub[3:0]] != '0)
        begin
            cls = BGP_CLASS[rsub[3:0]] | (9'd1 << CF_EXT);
        end
        else if (rtype == TYPE_TABLE_DUMP_V2 && rsub < 16'd13)
        begin
            cls = DUMP2_CLASS[rsub[3:0]];
        end
        return cls;
    endfunction

    // Body bytes available; extended records carry the stamp inside the length
    function automatic logic [31:0] avail_len(input logic [31:0] len, input logic ext);
        logic [31:0] avail;
        if (!ext)
        begin
            avail = len;
        end
        else if (len < EXT_STAMP_LEN)
        begin
            avail = '0;
        end
        else
        begin
            avail = len - EXT_STAMP_LEN;
        end
        return avail;
    endfunction

    // True when a group of size bytes starting at used fits the body
    function automatic logic fits(input logic [POS_W-1:0] used, input logic [POS_W-1:0] size,
                                  input logic [31:0] avail);
        logic [POS_W:0] total;
        total = {1'b0, used} + {1'b0, size};
        return 32'(total) <= avail;
    endfunction

endpackage

/* design/mrt_hdr_stream_if.sv */
// Valid/ready stream interface carrying one payload beat per handshake.
interface mrt_hdr_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* design/mrt_record_header_parser_unit.sv */
// MRT record header parser top level: byte hold stage, field decoder, result queue.
// Flow: an accepted byte is registered in the hold stage and decoded from it when the queue
//   has room; the queue then offers its results one per cycle while the sink is ready.
// Throughput: one byte per cycle while the result queue keeps three free entries;
//   results leave at one per cycle while the sink is ready, so the queue sets sustained rate.
// Reset: rst_n clears the hold stage, the parse state and the queue at once; no clearing pass.
module mrt_record_header_parser_unit
    import mrt_hdr_pkg::*;
#(
    parameter int QUEUE_DEPTH = RESULT_QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    mrt_hdr_stream_if.sink    rec_bytes,
    mrt_hdr_stream_if.source  fields
);

    logic             hold_valid_reg;
    logic             hold_valid_next;
    rec_beat_t        hold_reg;
    logic             room;
    logic             step_go;
    logic             accept;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [63:0]      shift_reg;
    logic [63:0]      shift_next;
    logic [15:0]      type_reg;
    logic [15:0]      type_next;
    logic [15:0]      subtype_reg;
    logic [15:0]      subtype_next;
    logic [31:0]      length_reg;
    logic [31:0]      length_next;
    logic [8:0]       class_reg;
    logic [8:0]       class_next;
    logic             afi_v4_reg;
    logic             afi_v4_next;
    status_t          error_reg;
    status_t          error_next;
    logic             done_reg;
    logic             done_next;

    logic [63:0]      shift_cat;
    logic [8:0]       cls_new;
    logic [31:0]      len_new;
    logic [31:0]      avail_hdr;
    logic [31:0]      avail_cur;
    logic [POS_W-1:0] as_len;
    logic [POS_W-1:0] as_len_new;
    logic [POS_W-1:0] hdr_end;
    logic [POS_W-1:0] off;
    logic [POS_W-1:0] a0;
    logic [POS_W-1:0] alen;
    logic [POS_W-1:0] s0;
    logic [POS_W-1:0] rel;
    logic [15:0]      afi_val;
    logic             afi_v4_new;
    logic [POS_W-1:0] alen_new;
    logic [41:0]      nsec;
    logic             addr_last;
    status_t          status_val;
    result_bundle_t   bundle;

    // Append one result to the bundle of this byte
    function automatic result_bundle_t add_result(input result_bundle_t bin,
                                                  input field_code_t code,
                                                  input logic [63:0] val,
                                                  input logic last);
        result_bundle_t bout;
        bout = bin;
        bout.item[bin.count].field_code = code;
        bout.item[bin.count].value      = val;
        bout.item[bin.count].is_last    = last;
        bout.count = bin.count + RES_CNT_W'(1);
        return bout;
    endfunction

    // Hold stage handshake
    assign step_go         = hold_valid_reg && room;
    assign rec_bytes.ready = !hold_valid_reg || room;
    assign accept          = rec_bytes.valid && rec_bytes.ready;
    assign hold_valid_next = accept ? 1'b1 : (step_go ? 1'b0 : hold_valid_reg);

    // Decode the held byte against the current position
    always_comb
    begin
        shift_cat  = {shift_reg[55:0], hold_reg.data_byte};
        cls_new    = classify(type_reg, subtype_reg);
        len_new    = shift_cat[31:0];
        avail_hdr  = avail_len(len_new, cls_new[CF_EXT]);
        avail_cur  = avail_len(length_reg, class_reg[CF_EXT]);
        as_len     = class_reg[CF_AS32] ? AS4_LEN : AS2_LEN;
        as_len_new = cls_new[CF_AS32] ? AS4_LEN : AS2_LEN;
        hdr_end    = class_reg[CF_EXT] ? EXT_HDR_LEN : HDR_LEN;
        off        = pos_reg - hdr_end;
        a0         = (as_len << 1) + IFACE_AFI_LEN;
        alen       = afi_v4_reg ? V4_LEN : V6_LEN;
        s0         = a0 + (alen << 1);
        rel        = off - a0;
        afi_val    = shift_cat[15:0];
        afi_v4_new = (afi_val == ADDR_FAMILY_V4);
        alen_new   = afi_v4_new ? V4_LEN : V6_LEN;
        nsec       = 42'(shift_cat[31:0]) * 42'(NS_PER_US);
        addr_last  = 1'b0;
        status_val = ST_OK;

        pos_next     = pos_reg;
        shift_next   = shift_reg;
        type_next    = type_reg;
        subtype_next = subtype_reg;
        length_next  = length_reg;
        class_next   = class_reg;
        afi_v4_next  = afi_v4_reg;
        error_next   = error_reg;
        done_next    = done_reg;
        bundle       = '0;

        if (step_go && !done_reg)
        begin
            shift_next = shift_cat;
            if (pos_reg < HDR_LEN)
            begin
                // Common header
                case (pos_reg)
                    POS_SEC_END:
                    begin
                        bundle = add_result(bundle, FC_SEC, shift_cat, 1'b0);
                    end
                    POS_TYPE_END:
                    begin
                        type_next = shift_cat[15:0];
                        bundle = add_result(bundle, FC_TYPE, shift_cat, 1'b0);
                    end
                    POS_SUBTYPE_END:
                    begin
                        subtype_next = shift_cat[15:0];
                        bundle = add_result(bundle, FC_SUBTYPE, shift_cat, 1'b0);
                    end
                    POS_LEN_END:
                    begin
                        length_next = len_new;
                        class_next  = cls_new;
                        bundle = add_result(bundle, FC_LENGTH, shift_cat, 1'b0);
                        bundle = add_result(bundle, FC_CLASS, 64'(cls_new), 1'b0);
                        if (!cls_new[CF_VALID])
                        begin
                            error_next = ST_BAD_HEADER;
                            done_next  = 1'b1;
                        end
                        else if (!cls_new[CF_EXT])
                        begin
                            if (!cls_new[CF_BGP])
                            begin
                                done_next = 1'b1;
                            end
                            else if (!fits('0, as_len_new << 1, avail_hdr))
                            begin
                                error_next = ST_TRUNCATED;
                                done_next  = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (class_reg[CF_EXT] && pos_reg < EXT_HDR_LEN)
            begin
                // Microsecond stamp of extended-time records
                if (pos_reg == EXT_HDR_LEN - POS_W'(1))
                begin
                    bundle = add_result(bundle, FC_NSEC, 64'(nsec), 1'b0);
                    if (!class_reg[CF_BGP])
                    begin
                        done_next = 1'b1;
                    end
                    else if (!fits('0, as_len << 1, avail_cur))
                    begin
                        error_next = ST_TRUNCATED;
                        done_next  = 1'b1;
                    end
                end
            end
            else
            begin
                // BGP4MP body
                if (off == as_len - POS_W'(1))
                begin
                    bundle = add_result(bundle, FC_PEER_AS, shift_cat, 1'b0);
                end
                else if (off == (as_len << 1) - POS_W'(1))
                begin
                    bundle = add_result(bundle, FC_LOCAL_AS, shift_cat, 1'b0);
                    if (!fits(as_len << 1, IFACE_AFI_LEN, avail_cur))
                    begin
                        error_next = ST_TRUNCATED;
                        done_next  = 1'b1;
                    end
                end
                else if (off == (as_len << 1) + POS_W'(1))
                begin
                    bundle = add_result(bundle, FC_IFACE, shift_cat, 1'b0);
                end
                else if (off == (as_len << 1) + POS_W'(3))
                begin
                    afi_v4_next = afi_v4_new;
                    bundle = add_result(bundle, FC_AFI, shift_cat, 1'b0);
                    if (afi_val != ADDR_FAMILY_V4 && afi_val != ADDR_FAMILY_V6)
                    begin
                        error_next = ST_BAD_AFI;
                        done_next  = 1'b1;
                    end
                    else if (!fits(a0, alen_new << 1, avail_cur))
                    begin
                        error_next = ST_TRUNCATED;
                        done_next  = 1'b1;
                    end
                end
                else if (off >= a0 && off < s0)
                begin
                    if (afi_v4_reg)
                    begin
                        if (rel == V4_LEN - POS_W'(1))
                        begin
                            bundle = add_result(bundle, FC_PEER_ADDR_LO, shift_cat, 1'b0);
                        end
                        else if (rel == (V4_LEN << 1) - POS_W'(1))
                        begin
                            bundle = add_result(bundle, FC_LOCAL_ADDR_LO, shift_cat, 1'b0);
                            addr_last = 1'b1;
                        end
                    end
                    else
                    begin
                        if (rel == ADDR_WORD_LEN - POS_W'(1))
                        begin
                            bundle = add_result(bundle, FC_PEER_ADDR_HI, shift_cat, 1'b0);
                        end
                        else if (rel == V6_LEN - POS_W'(1))
                        begin
                            bundle = add_result(bundle, FC_PEER_ADDR_LO, shift_cat, 1'b0);
                        end
                        else if (rel == V6_LEN + ADDR_WORD_LEN - POS_W'(1))
                        begin
                            bundle = add_result(bundle, FC_LOCAL_ADDR_HI, shift_cat, 1'b0);
                        end
                        else if (rel == (V6_LEN << 1) - POS_W'(1))
                        begin
                            bundle = add_result(bundle, FC_LOCAL_ADDR_LO, shift_cat, 1'b0);
                            addr_last = 1'b1;
                        end
                    end
                    // After the local address: payload length if the subtype wraps, then the state check
                    if (addr_last)
                    begin
                        if (class_reg[CF_WRAPS])
                        begin
                            bundle = add_result(bundle, FC_PAYLOAD_LEN,
                                                64'(avail_cur - 32'(s0)), 1'b0);
                        end
                        if (!class_reg[CF_STATE])
                        begin
                            done_next = 1'b1;
                        end
                        else if (!fits(s0, STATE_PAIR_LEN, avail_cur))
                        begin
                            error_next = ST_TRUNCATED;
                            done_next  = 1'b1;
                        end
                    end
                end
                else if (off == s0 + POS_W'(1))
                begin
                    bundle = add_result(bundle, FC_OLD_STATE, shift_cat, 1'b0);
                end
                else if (off == s0 + POS_W'(3))
                begin
                    bundle = add_result(bundle, FC_NEW_STATE, shift_cat, 1'b0);
                    done_next = 1'b1;
                end
            end
            // Drop the accumulated bytes once a field is out
            if (bundle.count != '0)
            begin
                shift_next = '0;
            end
        end

        // Advance the saturating byte position
        if (step_go && pos_reg != POS_MAX)
        begin
            pos_next = pos_reg + POS_W'(1);
        end

        // Close the record: status, then clear all parse state
        if (step_go && hold_reg.record_end)
        begin
            if (done_next)
            begin
                status_val = error_next;
            end
            else if (pos_reg < POS_LEN_END)
            begin
                status_val = ST_BAD_HEADER;
            end
            else
            begin
                status_val = ST_TRUNCATED;
            end
            bundle = add_result(bundle, FC_STATUS, 64'(status_val), 1'b1);
            pos_next     = '0;
            shift_next   = '0;
            type_next    = '0;
            subtype_next = '0;
            length_next  = '0;
            class_next   = '0;
            afi_v4_next  = 1'b0;
            error_next   = ST_OK;
            done_next    = 1'b0;
        end
    end

    // Hold and parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            pos_reg        <= '0;
            shift_reg      <= '0;
            type_reg       <= '0;
            subtype_reg    <= '0;
            length_reg     <= '0;
            class_reg      <= '0;
            afi_v4_reg     <= 1'b0;
            error_reg      <= ST_OK;
            done_reg       <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            pos_reg        <= pos_next;
            shift_reg      <= shift_next;
            type_reg       <= type_next;
            subtype_reg    <= subtype_next;
            length_reg     <= length_next;
            class_reg      <= class_next;
            afi_v4_reg     <= afi_v4_next;
            error_reg      <= error_next;
            done_reg       <= done_next;
        end
    end

    // Capture the incoming beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg <= rec_bytes.payload;
        end
    end

    mrt_hdr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (bundle),
        .room   (room),
        .fields (fields)
    );

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step_go && hold_reg.record_end |=> pos_reg == '0 && !done_reg && class_reg == '0
                                           && shift_reg == '0)
        else $error("parse state not cleared after record end");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        step_go && done_reg && !hold_reg.record_end |-> bundle.count == '0)
        else $error("result produced after parsing finished");

    a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
        step_go && hold_reg.record_end |-> bundle.count != '0)
        else $error("record end produced no status");

endmodule

/* design/mrt_hdr_queue.sv */
// Result queue: takes up to three results per cycle, delivers one per beat.
module mrt_hdr_queue
    import mrt_hdr_pkg::*;
#(
    parameter int DEPTH = RESULT_QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  result_bundle_t         push,
    output logic                   room,
    mrt_hdr_stream_if.source       fields
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               pop;

    // Advance a pointer by k entries around the ring
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
                                                  input logic [RES_CNT_W-1:0] k);
        logic [PTR_W:0] sum;
        sum = {1'b0, ptr} + (PTR_W + 1)'(k);
        if (sum >= (PTR_W + 1)'(DEPTH))
        begin
            sum = sum - (PTR_W + 1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    // Offer the head entry
    assign fields.valid   = (count_reg != '0);
    assign fields.payload = entry_reg[rd_ptr_reg];
    assign pop            = fields.valid && fields.ready;
    assign room           = (count_reg <= CNT_W'(DEPTH - MAX_RESULTS));

    // Move pointers and fill level
    always_comb
    begin
        wr_ptr_next = wrap_add(wr_ptr_reg, push.count);
        rd_ptr_next = pop ? wrap_add(rd_ptr_reg, RES_CNT_W'(1)) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the new results behind the tail
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (RES_CNT_W'(k) < push.count)
            begin
                entry_reg[wrap_add(wr_ptr_reg, RES_CNT_W'(k))] <= push.item[k];
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != '0 |-> room && push.count <= RES_CNT_W'(MAX_RESULTS))
        else $error("results pushed without room");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg == $past(count_reg) + CNT_W'($past(push.count))
                              - CNT_W'($past(pop)))
        else $error("result queue fill level lost track");

endmodule
